// ===== rtl/core/modular_arithmetic_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the modular arithmetic unit
// Same-cycle and next-cycle implication checks, compiled out by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MAU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular arithmetic unit check failed");
`define MAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular arithmetic unit check failed");
`else
`define MAU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/mau_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular arithmetic unit package
// Payload structs, command codes and sequencer states.
// ---------------------------------------------------------------------------
package mau_pkg;

   localparam int DATA_W        = 64;
   localparam int CMD_W         = 3;
   localparam int DEFAULT_WIDTH = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_NEG = 3'd1,
      CMD_SUB = 3'd2,
      CMD_MUL = 3'd3,
      CMD_INV = 3'd4,
      CMD_DIV = 3'd5,
      CMD_POW = 3'd6
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_MUL_DBL,
      ST_MUL_ADD,
      ST_MUL_END,
      ST_PW_CHK,
      ST_INV_START,
      ST_EU_CHK,
      ST_EU_DIV,
      ST_EU_ACC,
      ST_EU_UPD,
      ST_INV_END,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/modular_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// Modular arithmetic unit
// Add, negate, subtract, multiply, inverse, divide and power modulo a
// programmable modulus, computed by one modular adder and one divider step.
// ---------------------------------------------------------------------------
// Usage:
//  - csr_*: write the modulus while idle (csr_ready high when no item runs);
//    a write offered in idle wins over a new item, which waits while the write is offered.
//  - req_*: one item (cmd, operand_a, operand_b); req_stall is high while an
//    item is in work or a modulus write is offered, so one item runs at a time.
//  - rsp_*: one result item (value, error) per request, held in an output
//    register until taken; a stalled result blocks only the next finish.
// Steps per item (W = WIDTH):
//  - zero modulus: straight to an error result; else operands are first reduced.
//  - add, negate, subtract: one adder pass; multiply: double-and-add per bit.
//  - inverse: extended Euclid, each step a full division; divide adds a multiply.
//  - power: up to W exponent bits, each one or two multiplies.
// All steps run on the shared modular adder and the one-bit divider step.
// Reset clears the modulus to zero, drops any pending result and returns to
// idle; with a zero modulus every item reports an error.
// ---------------------------------------------------------------------------
`include "modular_arithmetic_unit_macros.svh"

module modular_arithmetic_unit
   import mau_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   state_type state_ff, state_in;

   logic [WIDTH-1:0] p_ff, p_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [WIDTH-1:0] raw_b_ff, raw_b_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0] x_ff, x_in, y_ff, y_in, acc_ff, acc_in;
   logic [WIDTH-1:0] t_ff, t_in, nt_ff, nt_in, r_ff, r_in, nr_ff, nr_in;
   logic [WIDTH-1:0] base_ff, base_in, e_ff, e_in, pacc_ff, pacc_in;
   logic [WIDTH-1:0] rem_ff, rem_in, dq_ff, dq_in;
   logic             qbit_ff, qbit_in, pw_sq_ff, pw_sq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic             err_ff, err_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_take, rsp_free;
   logic [WIDTH-1:0] inv_src;

   // shared modular add / subtract unit
   logic [WIDTH-1:0] mu_x, mu_y, mu_out;
   logic             mu_sub;
   logic [WIDTH:0]   mu_sum, mu_red, mu_dif;

   // shared divider step unit
   logic [WIDTH-1:0] dv_d, dv_rem;
   logic [WIDTH:0]   dv_sh, dv_dif;
   logic             dv_q;

   assign req_take = req_valid && !csr_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign inv_src  = (cmd_ff == CMD_INV) ? a_ff : b_ff;

   // operand select for the modular adder
   always_comb begin
      mu_x   = acc_ff;
      mu_y   = acc_ff;
      mu_sub = 1'b0;
      case (state_ff)
         ST_DISPATCH: begin
            mu_x   = (cmd_ff == CMD_NEG) ? '0 : a_ff;
            mu_y   = (cmd_ff == CMD_NEG) ? a_ff : b_ff;
            mu_sub = (cmd_ff != CMD_ADD);
         end
         ST_MUL_ADD: mu_y = x_ff;
         ST_EU_ACC:  mu_y = nt_ff;
         ST_EU_UPD: begin
            mu_x   = t_ff;
            mu_sub = 1'b1;
         end
         default: begin
            mu_x = acc_ff;
         end
      endcase
   end

   // x + y or x - y, folded back into [0, p)
   always_comb begin
      mu_sum = {1'b0, mu_x} + {1'b0, mu_y};
      mu_red = mu_sum - {1'b0, p_ff};
      mu_dif = {1'b0, mu_x} - {1'b0, mu_y};
      if (mu_sub) begin
         mu_out = mu_dif[WIDTH] ? (mu_dif[WIDTH-1:0] + p_ff) : mu_dif[WIDTH-1:0];
      end else begin
         mu_out = mu_red[WIDTH] ? mu_sum[WIDTH-1:0] : mu_red[WIDTH-1:0];
      end
   end

   // restoring division, one quotient bit per step
   always_comb begin
      dv_d   = (state_ff == ST_EU_DIV) ? nr_ff : p_ff;
      dv_sh  = {rem_ff, dq_ff[WIDTH-1]};
      dv_dif = dv_sh - {1'b0, dv_d};
      dv_q   = !dv_dif[WIDTH];
      dv_rem = dv_q ? dv_dif[WIDTH-1:0] : dv_sh[WIDTH-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = (p_ff == '0) ? ST_DONE : ST_RED_A;
         end
         ST_RED_A: if (cnt_ff == CNT_W'(1)) state_in = ST_RED_B;
         ST_RED_B: if (cnt_ff == CNT_W'(1)) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_MUL: state_in = ST_MUL_DBL;
               CMD_INV: state_in = ST_INV_START;
               CMD_DIV: state_in = ST_INV_START;
               CMD_POW: state_in = ST_PW_CHK;
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL_DBL: begin
            if (y_ff[WIDTH-1])            state_in = ST_MUL_ADD;
            else if (cnt_ff == CNT_W'(1)) state_in = ST_MUL_END;
         end
         ST_MUL_ADD: state_in = (cnt_ff == '0) ? ST_MUL_END : ST_MUL_DBL;
         ST_MUL_END: begin
            if (cmd_ff == CMD_POW) state_in = pw_sq_ff ? ST_PW_CHK : ST_MUL_DBL;
            else                   state_in = ST_DONE;
         end
         ST_PW_CHK:    state_in = (e_ff == '0) ? ST_DONE : ST_MUL_DBL;
         ST_INV_START: state_in = (inv_src == '0) ? ST_DONE : ST_EU_CHK;
         ST_EU_CHK:    state_in = (nr_ff == '0) ? ST_INV_END : ST_EU_DIV;
         ST_EU_DIV:    state_in = ST_EU_ACC;
         ST_EU_ACC:    state_in = (cnt_ff == '0) ? ST_EU_UPD : ST_EU_DIV;
         ST_EU_UPD:    state_in = ST_EU_CHK;
         ST_INV_END: begin
            if (r_ff != WIDTH'(1) || cmd_ff == CMD_INV) state_in = ST_DONE;
            else                                        state_in = ST_MUL_DBL;
         end
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE) || csr_valid;
      csr_ready = (state_ff == ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   // datapath
   always_comb begin
      p_in         = p_ff;
      cmd_in       = cmd_ff;
      raw_b_in     = raw_b_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      nt_in        = nt_ff;
      r_in         = r_ff;
      nr_in        = nr_ff;
      base_in      = base_ff;
      e_in         = e_ff;
      pacc_in      = pacc_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      qbit_in      = qbit_ff;
      pw_sq_in     = pw_sq_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) p_in = csr_data[WIDTH-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_data.cmd;
               raw_b_in = req_data.operand_b[WIDTH-1:0];
               dq_in    = req_data.operand_a[WIDTH-1:0];
               rem_in   = '0;
               cnt_in   = CNT_W'(WIDTH);
               res_in   = '0;
               err_in   = 1'b1;
            end
         end
         ST_RED_A: begin
            rem_in = dv_rem;
            dq_in  = {dq_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               a_in   = dv_rem;
               rem_in = '0;
               dq_in  = raw_b_ff;
               cnt_in = CNT_W'(WIDTH);
            end
         end
         ST_RED_B: begin
            rem_in = dv_rem;
            dq_in  = {dq_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) b_in = dv_rem;
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_ADD, CMD_NEG, CMD_SUB: begin
                  res_in = mu_out;
                  err_in = 1'b0;
               end
               CMD_MUL: begin
                  x_in   = a_ff;
                  y_in   = b_ff;
                  acc_in = '0;
                  cnt_in = CNT_W'(WIDTH);
               end
               CMD_POW: begin
                  pacc_in = (p_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
                  base_in = a_ff;
                  e_in    = raw_b_ff;
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         // multiply: Horner over the multiplier bits, top bit first
         ST_MUL_DBL: begin
            acc_in = mu_out;
            y_in   = {y_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_MUL_ADD: acc_in = mu_out;
         ST_MUL_END: begin
            if (cmd_ff == CMD_POW) begin
               if (pw_sq_ff) begin
                  base_in = acc_ff;
                  e_in    = e_ff >> 1;
               end else begin
                  pacc_in  = acc_ff;
                  pw_sq_in = 1'b1;
                  x_in     = base_ff;
                  y_in     = base_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_W'(WIDTH);
               end
            end else begin
               res_in = acc_ff;
               err_in = 1'b0;
            end
         end
         // power: multiply into the accumulator on a set bit, then square
         ST_PW_CHK: begin
            if (e_ff == '0) begin
               res_in = pacc_ff;
               err_in = 1'b0;
            end else begin
               pw_sq_in = !e_ff[0];
               x_in     = e_ff[0] ? pacc_ff : base_ff;
               y_in     = base_ff;
               acc_in   = '0;
               cnt_in   = CNT_W'(WIDTH);
            end
         end
         ST_INV_START: begin
            t_in  = '0;
            nt_in = WIDTH'(1);
            r_in  = p_ff;
            nr_in = inv_src;
         end
         ST_EU_CHK: begin
            rem_in = '0;
            dq_in  = r_ff;
            acc_in = '0;
            cnt_in = CNT_W'(WIDTH);
         end
         // quotient bits feed q * nt mod p while the division runs
         ST_EU_DIV: begin
            rem_in  = dv_rem;
            dq_in   = {dq_ff[WIDTH-2:0], 1'b0};
            qbit_in = dv_q;
            acc_in  = mu_out;
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         ST_EU_ACC: if (qbit_ff) acc_in = mu_out;
         ST_EU_UPD: begin
            t_in  = nt_ff;
            nt_in = mu_out;
            r_in  = nr_ff;
            nr_in = rem_ff;
         end
         ST_INV_END: begin
            if (r_ff == WIDTH'(1)) begin
               if (cmd_ff == CMD_INV) begin
                  res_in = t_ff;
                  err_in = 1'b0;
               end else begin
                  x_in   = a_ff;
                  y_in   = t_ff;
                  acc_in = '0;
                  cnt_in = CNT_W'(WIDTH);
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.value = err_ff ? '0 : DATA_W'(res_ff);
               rsp_in.error = err_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      raw_b_ff <= raw_b_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      t_ff     <= t_in;
      nt_ff    <= nt_in;
      r_ff     <= r_in;
      nr_ff    <= nr_in;
      base_ff  <= base_in;
      e_ff     <= e_in;
      pacc_ff  <= pacc_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      qbit_ff  <= qbit_in;
      pw_sq_ff <= pw_sq_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   // checks
   `MAU_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid_ff && rsp_ff.error, rsp_ff.value == '0)
   `MAU_ASSERT_SAME(a_val_range, clock, reset, rsp_valid_ff && !rsp_ff.error,
                    DATA_W'(p_ff) > rsp_ff.value)
   `MAU_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives command items under random gaps and result stalls, predicts each
// result with an independent modular arithmetic model and compares in order.
// ---------------------------------------------------------------------------
module tb;
   import mau_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam logic [63:0]      ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [DATA_W-1:0] csr_data = '0;

   rsp_type     pending_results[$];
   logic [63:0] cur_modulus = '0;
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          moduli_used = 0;
   bit          no_gaps = 1'b0;

   modular_arithmetic_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ---- modular arithmetic model -------------------------------------------
   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] p);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, p});
   endfunction

   function automatic logic [63:0] submod(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] p);
      return (a >= b) ? a - b : a + (p - b);
   endfunction

   // extended Euclid on residues; ok cleared when no inverse exists
   function automatic logic [63:0] invmod(logic [63:0] a, logic [63:0] p,
                                          output bit ok);
      logic [63:0] t, nt, r, nr, q, tmp;
      t = '0; nt = 64'd1 % p; r = p; nr = a;
      ok = 1'b0;
      if (a == 0) return '0;
      while (nr != 0) begin
         q   = r / nr;
         tmp = submod(t, mulmod(q % p, nt, p), p);
         t   = nt;
         nt  = tmp;
         tmp = r - q * nr;
         r   = nr;
         nr  = tmp;
      end
      ok = (r == 1);
      return ok ? t : '0;
   endfunction

   function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e,
                                          logic [63:0] p);
      logic [63:0] acc;
      acc = 64'd1 % p;
      while (e != 0) begin
         if (e[0]) acc = mulmod(acc, base, p);
         base = mulmod(base, base, p);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic rsp_type predict_result(req_type item, logic [63:0] p);
      rsp_type     res;
      logic [63:0] a, b, v;
      logic [64:0] sum;
      bit          ok;
      res = '0;
      if (p == 0) begin
         res.error = 1'b1;
         return res;
      end
      a = item.operand_a % p;
      b = item.operand_b % p;
      ok = 1'b1;
      v = '0;
      case (item.cmd)
         CMD_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            v = (sum >= {1'b0, p}) ? 64'(sum - {1'b0, p}) : sum[63:0];
         end
         CMD_NEG: v = submod(64'd0, a, p);
         CMD_SUB: v = submod(a, b, p);
         CMD_MUL: v = mulmod(a, b, p);
         CMD_INV: v = invmod(a, p, ok);
         CMD_DIV: begin
            v = invmod(b, p, ok);
            if (ok) v = mulmod(a, v, p);
         end
         CMD_POW: v = powmod(a, item.operand_b, p);
         default: ok = 1'b0;
      endcase
      res.value = ok ? v : '0;
      res.error = !ok;
      return res;
   endfunction

   // ---- checking -----------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h/%b",
                                      rsp_data.value, rsp_data.error));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.value !== want.value)
               report_mismatch($sformatf("value %h, want %h",
                                         rsp_data.value, want.value));
            if (rsp_data.error !== want.error)
               report_mismatch($sformatf("error %b, want %b",
                                         rsp_data.error, want.error));
         end
      end
   end

   // result side back-pressure: a random stall before each result is taken
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---- stimulus helpers ---------------------------------------------------
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [63:0] a, logic [63:0] b);
      req_type item;
      int      gap;
      item.cmd = cmd; item.operand_a = a; item.operand_b = b;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      pending_results.push_back(predict_result(item, cur_modulus));
      items_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_modulus(logic [63:0] m);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_modulus = m;
      moduli_used++;
   endtask

   // operand biased toward the edges of the current modulus
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ALL_ONES;
         2: return cur_modulus - 1;
         3: return cur_modulus;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      return ($urandom_range(0, 15) == 0) ? CMD_UNUSED
                                          : CMD_W'($urandom_range(0, 6));
   endfunction

   // ---- tests --------------------------------------------------------------
   task automatic test_zero_modulus();
      send_item(CMD_ADD, 64'd5, 64'd7);
      send_item(CMD_INV, 64'd3, '0);
      send_item(CMD_POW, 64'd2, 64'd10);
   endtask

   task automatic test_modulus_one();
      set_modulus(64'd1);
      send_item(CMD_POW, 64'd9, 64'd0);
      send_item(CMD_INV, 64'd9, '0);
      send_item(CMD_DIV, 64'd4, 64'd5);
      send_item(CMD_MUL, ALL_ONES, ALL_ONES);
   endtask

   task automatic test_directed();
      set_modulus(ALL_ONES);
      send_item(CMD_ADD, ALL_ONES, ALL_ONES);
      send_item(CMD_ADD, ALL_ONES - 1, ALL_ONES - 1);
      send_item(CMD_NEG, '0, ALL_ONES);
      send_item(CMD_SUB, 64'd1, ALL_ONES - 1);
      send_item(CMD_MUL, ALL_ONES - 1, ALL_ONES - 1);
      send_item(CMD_INV, 64'd3, '0);      // shares a factor with 2^64-1
      send_item(CMD_INV, 64'd2, '0);
      send_item(CMD_DIV, 64'd7, '0);      // divide by zero
      set_modulus(64'hFFFF_FFFF_FFFF_FFC5); // largest 64-bit prime
      send_item(CMD_INV, '0, '0);
      send_item(CMD_INV, ALL_ONES, '0);
      send_item(CMD_DIV, 64'h1234_5678_9ABC_DEF0, ALL_ONES);
      send_item(CMD_POW, 64'd3, '0);
      send_item(CMD_POW, ALL_ONES, ALL_ONES);
      send_item(CMD_UNUSED, 64'd1, 64'd2);
      set_modulus(64'd12);
      send_item(CMD_INV, 64'd5, '0);
      send_item(CMD_DIV, 64'd6, 64'd9);   // non-invertible divisor
      send_item(CMD_POW, '0, '0);
   endtask

   task automatic test_random(int count);
      logic [63:0] moduli[6];
      logic [63:0] b;
      logic [CMD_W-1:0] c;
      moduli[0] = {$urandom, $urandom};
      moduli[1] = 64'd1000003;
      moduli[2] = 64'h8000_0000_0000_0000;
      moduli[3] = 64'($urandom_range(2, 300));
      moduli[4] = 64'h1FFF_FFFF_FFFF_FFFF;
      moduli[5] = {$urandom | 32'h8000_0000, $urandom | 32'd1};
      for (int m = 0; m < 6; m++) begin
         set_modulus(moduli[m]);
         no_gaps = (m == 2);
         for (int i = 0; i < count / 6; i++) begin
            c = pick_cmd();
            b = pick_operand();
            // keep most exponents short so power stays quick
            if (c == CMD_POW && $urandom_range(0, 7) != 0)
               b = 64'($urandom_range(0, 255));
            send_item(c, pick_operand(), b);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_modulus();
      test_modulus_one();
      test_directed();
      test_random(78);
      drain();
      repeat (50) @(posedge clock);
      $display("Ran %0d items over %0d moduli, %0d results checked.",
               items_sent, moduli_used, results_seen);
      $display("Covered all commands, zero and unit moduli, non-invertible operands.");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
